// ----- design/assert_macros.svh -----
// Assertion macros shared by the RTL in this folder.
// Each macro expects clk and arst_n to be visible where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define XKB_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked out of reset.
`define XKB_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- design/xkb64_pkg.sv -----
// Package for the XOR-key Base64 codec: item mode and direction codes, result
// record, and the character conversion functions. Used by xor_key_base64_codec_top.
package xkb64_pkg;

	localparam logic [1:0] MODE_START = 2'd0;
	localparam logic [1:0] MODE_KEY   = 2'd1;
	localparam logic [1:0] MODE_BYTE  = 2'd2;
	localparam logic [1:0] MODE_END   = 2'd3;

	localparam logic DIR_ENCODE = 1'b0;
	localparam logic DIR_DECODE = 1'b1;

	localparam logic [7:0] PAD_CHAR = 8'h3D;   // '='

	typedef struct packed {
		logic [7:0] out_byte;
		logic       has_byte;
		logic       eom;
		logic       last;
	} res_t;

	// 6-bit value to Base64 character
	function automatic logic [7:0] enc_char(input logic [5:0] v);
		logic [7:0] c;
		if (v < 6'd26)      c = 8'h41 + {2'b00, v};
		else if (v < 6'd52) c = 8'h61 + {2'b00, v - 6'd26};
		else if (v < 6'd62) c = 8'h30 + {2'b00, v - 6'd52};
		else if (v == 6'd62) c = 8'h2B;
		else                c = 8'h2F;
		return c;
	endfunction

	// Base64 character to {valid, 6-bit value}
	function automatic logic [6:0] dec_char(input logic [7:0] c);
		logic [6:0] r;
		if (c >= 8'h41 && c <= 8'h5A)      r = {1'b1, 6'(c - 8'h41)};
		else if (c >= 8'h61 && c <= 8'h7A) r = {1'b1, 6'(c - 8'h61 + 8'd26)};
		else if (c >= 8'h30 && c <= 8'h39) r = {1'b1, 6'(c - 8'h30 + 8'd52)};
		else if (c == 8'h2B)               r = {1'b1, 6'd62};
		else if (c == 8'h2F)               r = {1'b1, 6'd63};
		else                               r = 7'd0;
		return r;
	endfunction

	// dash, colon, space and tab..CR are not counted in the key
	function automatic logic is_skipped_key(input logic [7:0] c);
		return (c == 8'h2D) || (c == 8'h3A) || (c == 8'h20) ||
			(c >= 8'h09 && c <= 8'h0D);
	endfunction

endpackage

// ----- design/xor_key_base64_codec_top.sv -----
// XOR-key Base64 codec, top level.
// Depends on xkb64_pkg and assert_macros.svh.
//
// An accepted item is worked out in the cycle of its transfer: the key and the
// bit accumulator update at once and the item's zero to three results land in
// a three-slot result buffer, which drives the output one result per cycle
// while out_ready is high. A new item is taken while the buffer is empty or while
// its final result is being transferred, so an item is taken only once the results
// of the last one are leaving. An encoded byte gives one or two characters (four
// characters for every three bytes), a decoded character at most one byte, key
// and start items none, and an end marker one to three results. The direction
// register is written through cfg_we/cfg_wdata and should only change between
// items.
module xor_key_base64_codec_top
	import xkb64_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic       cfg_wdata,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] mode,
	input  logic [7:0] data_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic       has_byte,
	output logic       end_of_message,
	output logic       last
);

	logic       dir_q;
	logic [7:0] key_q;
	logic       key_odd_q;
	logic [5:0] pend_bits_q;
	logic [2:0] pend_cnt_q;

	res_t       slot_q [3];
	logic [1:0] buf_cnt_q;

	logic in_xfer, out_xfer;

	// next state and results of the item on the inputs
	logic [2:0]  nn;
	logic [7:0]  x;
	logic [13:0] acc_e, al_e;
	logic [3:0]  t_e, rem_e;
	logic        two_e;
	logic [6:0]  dv;
	logic [11:0] acc_d, al_d;
	logic [3:0]  t_d, rem_d;
	logic [11:0] mask_d;
	logic [13:0] mask_e;
	logic [5:0]  tail;

	res_t       res [3];
	logic [1:0] n_res;
	logic [7:0] key_d;
	logic       key_odd_d;
	logic [5:0] pend_bits_d;
	logic [2:0] pend_cnt_d;

	assign out_valid = (buf_cnt_q != 2'd0);
	assign out_xfer  = out_valid && out_ready;
	assign in_ready  = (buf_cnt_q == 2'd0) || ((buf_cnt_q == 2'd1) && out_ready);
	assign in_xfer   = in_valid && in_ready;

	assign out_byte       = slot_q[0].out_byte;
	assign has_byte       = slot_q[0].has_byte;
	assign end_of_message = slot_q[0].eom;
	assign last           = slot_q[0].last;

	always_comb begin
		nn    = (pend_cnt_q > 3'd6) ? 3'd6 : pend_cnt_q;
		x     = data_byte ^ key_q;

		// encode: byte joins the pending bits, one or two characters leave
		acc_e = {pend_bits_q, x};
		al_e  = acc_e << (3'd6 - nn);
		t_e   = {1'b0, nn} + 4'd8;
		two_e = (t_e >= 4'd12);
		rem_e = two_e ? (t_e - 4'd12) : (t_e - 4'd6);
		mask_e = (14'd1 << rem_e) - 14'd1;

		// decode: six bits join, a byte leaves once eight are held
		dv    = dec_char(data_byte);
		acc_d = {pend_bits_q, dv[5:0]};
		al_d  = acc_d << (3'd6 - nn);
		t_d   = {1'b0, nn} + 4'd6;
		rem_d = (t_d >= 4'd8) ? (t_d - 4'd8) : t_d;
		mask_d = (12'd1 << rem_d) - 12'd1;

		tail  = pend_bits_q << (3'd6 - nn);

		key_d       = key_q;
		key_odd_d   = key_odd_q;
		pend_bits_d = pend_bits_q;
		pend_cnt_d  = pend_cnt_q;
		n_res       = 2'd0;
		for (int i = 0; i < 3; i++) res[i] = '0;

		unique case (mode)
			MODE_START: begin
				key_d       = '0;
				key_odd_d   = 1'b0;
				pend_bits_d = '0;
				pend_cnt_d  = '0;
			end
			MODE_KEY: begin
				if (!is_skipped_key(data_byte)) begin
					if (key_odd_q) key_d = key_q + data_byte;
					key_odd_d = ~key_odd_q;
				end
			end
			MODE_BYTE: begin
				if (dir_q == DIR_ENCODE) begin
					res[0].out_byte = enc_char(al_e[13:8]);
					res[0].has_byte = 1'b1;
					res[1].out_byte = enc_char(al_e[7:2]);
					res[1].has_byte = 1'b1;
					n_res       = two_e ? 2'd2 : 2'd1;
					pend_bits_d = 6'(acc_e & mask_e);
					pend_cnt_d  = 3'(rem_e);
				end else if (dv[6]) begin
					if (t_d >= 4'd8) begin
						res[0].out_byte = al_d[11:4] ^ key_q;
						res[0].has_byte = 1'b1;
						n_res = 2'd1;
					end
					pend_bits_d = 6'(acc_d & mask_d);
					pend_cnt_d  = 3'(rem_d);
				end
			end
			MODE_END: begin
				if (dir_q == DIR_ENCODE && nn != 3'd0) begin
					res[0].out_byte = enc_char(tail);
					res[0].has_byte = 1'b1;
					res[1].out_byte = PAD_CHAR;
					res[1].has_byte = 1'b1;
					res[2].out_byte = PAD_CHAR;
					res[2].has_byte = 1'b1;
					priority if (nn == 3'd2) n_res = 2'd3;
					else if (nn == 3'd4)     n_res = 2'd2;
					else                     n_res = 2'd1;
				end else begin
					n_res = 2'd1;   // bare end marker
				end
				for (int i = 0; i < 3; i++)
					res[i].eom = (2'(i + 1) == n_res);
				pend_bits_d = '0;
				pend_cnt_d  = '0;
			end
			default: ;
		endcase

		for (int i = 0; i < 3; i++)
			res[i].last = (2'(i + 1) == n_res);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dir_q       <= DIR_ENCODE;
			key_q       <= '0;
			key_odd_q   <= 1'b0;
			pend_bits_q <= '0;
			pend_cnt_q  <= '0;
			buf_cnt_q   <= '0;
		end else begin
			if (cfg_we) dir_q <= cfg_wdata;
			if (in_xfer) begin
				key_q       <= key_d;
				key_odd_q   <= key_odd_d;
				pend_bits_q <= pend_bits_d;
				pend_cnt_q  <= pend_cnt_d;
				buf_cnt_q   <= n_res;
			end else if (out_xfer) begin
				buf_cnt_q <= buf_cnt_q - 2'd1;
			end
		end
	end

	// result slots: loaded on an input transfer, shifted down on an output one
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			for (int i = 0; i < 3; i++) slot_q[i] <= res[i];
		end else if (out_xfer) begin
			slot_q[0] <= slot_q[1];
			slot_q[1] <= slot_q[2];
		end
	end

`include "assert_macros.svh"

	`XKB_ASSERT_NOW(a_eom_is_last, out_valid && end_of_message, last,
		"end of message not on the final result")
	`XKB_ASSERT_NEXT(a_end_gives_result, in_xfer && mode == MODE_END,
		out_valid && pend_cnt_q == 3'd0, "end item left no result or pending bits")
	`XKB_ASSERT_NOW(a_pend_even, 1'b1, !pend_cnt_q[0] && pend_cnt_q <= 3'd6,
		"pending bit count out of range")
	`XKB_ASSERT_NEXT(a_key_item_quiet, in_xfer && (mode == MODE_KEY || mode == MODE_START),
		!out_valid, "key or start item produced a result")

endmodule

// ----- tb/sv/tb.sv -----
// Self-checking testbench for xor_key_base64_codec_top.
// Needs xkb64_pkg and the codec RTL; a scoreboard class predicts each result
// from the accepted items and checks the output transfers in order.
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import xkb64_pkg::*;

	class codec_scoreboard;
		logic       dir;
		logic [7:0] key_sum;
		logic       key_odd;
		logic [5:0] held_bits;
		logic [2:0] held_count;
		res_t       expected_out[$];
		int         errors;

		function new();
			dir = DIR_ENCODE;
			key_sum = 8'h00;
			key_odd = 1'b0;
			held_bits = 6'd0;
			held_count = 3'd0;
			errors = 0;
		endfunction

		function logic [7:0] b64_char(logic [5:0] v);
			if (v < 26) return 8'("A" + v);
			if (v < 52) return 8'("a" + v - 26);
			if (v < 62) return 8'("0" + v - 52);
			return (v == 62) ? 8'h2B : 8'h2F;
		endfunction

		task report_mismatch(string what);
			errors++;
			if (errors <= 40) $display("[%0t] %s", $realtime, what);
		endtask

		// works out the results of one accepted input transfer
		function void predict_item(logic [1:0] md, logic [7:0] d);
			res_t        r[4];
			int          k;
			int          n;
			int          t;
			int          m;
			int          pads;
			int          v;
			logic [13:0] acc;
			logic [5:0]  p;
			k = 0;
			n = held_count;
			p = held_bits;
			if (n < 6) p = p & 6'((1 << n) - 1);
			case (md)
			MODE_START: begin
				key_sum = 8'h00;
				key_odd = 1'b0;
				held_bits = 6'd0;
				held_count = 3'd0;
			end
			MODE_KEY: begin
				if (!(d == "-" || d == ":" || d == " " || (d >= 8'h09 && d <= 8'h0D))) begin
					if (key_odd) key_sum = key_sum + d;
					key_odd = !key_odd;
				end
			end
			MODE_BYTE: begin
				if (dir == DIR_ENCODE) begin
					acc = {p, d ^ key_sum};
					t = n + 8;
					while (t >= 6) begin
						t -= 6;
						r[k] = '{b64_char(6'(acc >> t)), 1'b1, 1'b0, 1'b0};
						k++;
					end
					held_bits = 6'(acc & ((14'd1 << t) - 1));
					held_count = 3'(t);
				end else begin
					v = -1;
					if (d >= "A" && d <= "Z") v = d - "A";
					else if (d >= "a" && d <= "z") v = d - "a" + 26;
					else if (d >= "0" && d <= "9") v = d - "0" + 52;
					else if (d == "+") v = 62;
					else if (d == "/") v = 63;
					// characters outside the alphabet leave the state alone
					if (v >= 0) begin
						acc = {2'b00, p, 6'(v)};
						t = n + 6;
						if (t >= 8) begin
							t -= 8;
							r[k] = '{8'(acc >> t) ^ key_sum, 1'b1, 1'b0, 1'b0};
							k++;
						end
						held_bits = 6'(acc & ((14'd1 << t) - 1));
						held_count = 3'(t);
					end
				end
			end
			default: begin
				if (dir == DIR_ENCODE && n > 0) begin
					m = (n < 6) ? n : 6;
					pads = (m == 2) ? 2 : (m == 4) ? 1 : 0;
					r[k] = '{b64_char(6'(p << (6 - m))), 1'b1, 1'b0, 1'b0};
					k++;
					repeat (pads) begin
						r[k] = '{PAD_CHAR, 1'b1, 1'b0, 1'b0};
						k++;
					end
				end else begin
					r[k] = '{8'h00, 1'b0, 1'b0, 1'b0};
					k++;
				end
				r[k-1].eom = 1'b1;
				held_bits = 6'd0;
				held_count = 3'd0;
			end
			endcase
			if (k > 0) r[k-1].last = 1'b1;
			for (int i = 0; i < k; i++) expected_out.push_back(r[i]);
		endfunction

		task check_output(res_t got);
			res_t want;
			if (expected_out.size() == 0) begin
				report_mismatch($sformatf("result %h with nothing outstanding", got));
				return;
			end
			want = expected_out.pop_front();
			if (got.out_byte !== want.out_byte)
				report_mismatch($sformatf("out_byte %h, want %h", got.out_byte, want.out_byte));
			if (got.has_byte !== want.has_byte)
				report_mismatch($sformatf("has_byte %b, want %b", got.has_byte, want.has_byte));
			if (got.eom !== want.eom)
				report_mismatch($sformatf("end_of_message %b, want %b", got.eom, want.eom));
			if (got.last !== want.last)
				report_mismatch($sformatf("last %b, want %b", got.last, want.last));
		endtask
	endclass

	localparam logic [7:0] KEY_SEPARATORS[8] = '{"-", ":", " ", 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D};

	logic       clk;
	logic       arst_n;
	logic       cfg_we;
	logic       cfg_wdata;
	logic       in_valid;
	logic       in_ready;
	logic [1:0] mode;
	logic [7:0] data_byte;
	logic       out_valid;
	logic       out_ready;
	logic [7:0] out_byte;
	logic       has_byte;
	logic       end_of_message;
	logic       last;

	codec_scoreboard sb = new();
	int burst_left = 0;
	int items_sent = 0;

	xor_key_base64_codec_top DUT (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.mode           (mode),
		.data_byte      (data_byte),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.out_byte       (out_byte),
		.has_byte       (has_byte),
		.end_of_message (end_of_message),
		.last           (last)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("xor_key_base64_codec_top: mismatch");
		$finish;
	end

	// result side: out_ready follows a stall style that is picked anew at random after each run
	initial begin
		int style;
		int tick;
		out_ready = 1'b0;
		tick = 0;
		forever begin
			style = $urandom_range(0, 3);
			repeat ($urandom_range(20, 80)) begin
				@(negedge clk);
				tick++;
				case (style)
				0: out_ready = 1'b1;
				1: out_ready = 1'($urandom_range(0, 1));
				2: out_ready = (tick % 7) == 0;
				default: out_ready = $urandom_range(0, 9) != 0;
				endcase
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_output('{out_byte, has_byte, end_of_message, last});
	end

	// bursts of back-to-back transfers with random gaps in between
	task automatic send_item(logic [1:0] md, logic [7:0] d);
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
			repeat ($urandom_range(0, 6)) begin
				@(negedge clk);
				in_valid = 1'b0;
			end
		end
		burst_left--;
		@(negedge clk);
		in_valid = 1'b1;
		mode = md;
		data_byte = d;
		do @(posedge clk); while (!in_ready);
		sb.predict_item(md, d);
		items_sent++;
	endtask

	// hold off until every outstanding result has been seen
	task automatic drain();
		@(negedge clk);
		in_valid = 1'b0;
		while (sb.expected_out.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_direction(logic d);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_wdata = d;
		@(negedge clk);
		cfg_we = 1'b0;
		sb.dir = d;
	endtask

	function automatic logic [7:0] key_char();
		if ($urandom_range(0, 9) < 3) return KEY_SEPARATORS[$urandom_range(0, 7)];
		return 8'($urandom);
	endfunction

	task automatic random_message();
		int body;
		if ($urandom_range(0, 9) != 0) send_item(MODE_START, 8'($urandom));
		repeat ($urandom_range(0, 6)) send_item(MODE_KEY, key_char());
		body = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 24) : $urandom_range(0, 8);
		repeat (body) begin
			case ($urandom_range(0, 19))
			0: send_item(MODE_KEY, key_char());
			1: send_item(2'($urandom), 8'($urandom));
			2: begin
				// flip direction mid-message, held bits carry over
				drain();
				set_direction(!sb.dir);
			end
			default: begin
				if (sb.dir == DIR_DECODE && $urandom_range(0, 19) < 17)
					send_item(MODE_BYTE, sb.b64_char(6'($urandom)));
				else
					send_item(MODE_BYTE, 8'($urandom));
			end
			endcase
		end
		if ($urandom_range(0, 9) != 0) send_item(MODE_END, 8'($urandom));
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = 1'b0;
		in_valid = 1'b0;
		mode = MODE_START;
		data_byte = 8'h00;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// encode: key skipping, full group, two pads, one pad, bare end
		set_direction(DIR_ENCODE);
		send_item(MODE_START, 8'hFF);
		send_item(MODE_KEY, "a");
		send_item(MODE_KEY, " ");
		send_item(MODE_KEY, "-");
		send_item(MODE_KEY, ":");
		send_item(MODE_KEY, 8'h09);
		send_item(MODE_KEY, 8'h0D);
		send_item(MODE_KEY, "b");
		send_item(MODE_BYTE, 8'h00);
		send_item(MODE_BYTE, 8'hFF);
		send_item(MODE_BYTE, "Q");
		send_item(MODE_END, 8'hFF);
		send_item(MODE_BYTE, 8'h81);
		send_item(MODE_END, 8'h00);
		send_item(MODE_BYTE, 8'h01);
		send_item(MODE_BYTE, 8'h02);
		send_item(MODE_END, 8'h00);
		send_item(MODE_END, 8'h00);

		// decode: alphabet edges, pad and junk skipped, leftover bits dropped
		drain();
		set_direction(DIR_DECODE);
		send_item(MODE_START, 8'h00);
		send_item(MODE_KEY, 8'h08);
		send_item(MODE_KEY, 8'hFF);
		send_item(MODE_BYTE, "A");
		send_item(MODE_BYTE, "z");
		send_item(MODE_BYTE, "0");
		send_item(MODE_BYTE, "9");
		send_item(MODE_BYTE, "+");
		send_item(MODE_BYTE, "/");
		send_item(MODE_BYTE, "=");
		send_item(MODE_BYTE, 8'h00);
		send_item(MODE_BYTE, 8'hFF);
		send_item(MODE_END, 8'h00);

		// six held bits into the encoder, then four held bits into the decoder
		send_item(MODE_BYTE, "Q");
		drain();
		set_direction(DIR_ENCODE);
		send_item(MODE_BYTE, 8'hC3);
		send_item(MODE_BYTE, 8'h07);
		drain();
		set_direction(DIR_DECODE);
		send_item(MODE_BYTE, "g");
		send_item(MODE_END, 8'h00);

		while (items_sent < 350) begin
			if ($urandom_range(0, 2) == 0) begin
				drain();
				set_direction(1'($urandom_range(0, 1)));
			end
			random_message();
		end

		@(negedge clk);
		in_valid = 1'b0;
		while (sb.expected_out.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (sb.errors == 0)
			$display("xor_key_base64_codec_top: match");
		else
			$display("xor_key_base64_codec_top: mismatch");
		$finish;
	end

endmodule
